// ===== rtl/cel_pkg.sv =====
`default_nettype none

package cel_pkg;

    localparam int CodeW = 16;
    localparam int SevW  = 8;
    localparam int WordW = 32;
    localparam int AgeW  = 8;
    localparam int OpW   = 3;
    localparam int CntW  = 5;

    localparam logic [OpW-1:0] OP_RECORD = 3'd0;
    localparam logic [OpW-1:0] OP_READ   = 3'd1;
    localparam logic [OpW-1:0] OP_CLEAR  = 3'd2;
    localparam logic [OpW-1:0] OP_LATEST = 3'd3;
    localparam logic [OpW-1:0] OP_COUNT  = 3'd4;

    localparam logic CFG_LOG_ENABLE  = 1'b0;
    localparam logic CFG_BOOT_NUMBER = 1'b1;

    typedef struct packed {
        logic [WordW-1:0] boot;
        logic [WordW-1:0] tms;
        logic [WordW-1:0] ctx;
        logic [SevW-1:0]  sev;
        logic [CodeW-1:0] code;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic load;       // latch the input transaction
        logic rec;        // write an entry at the head
        logic clear;      // empty the ring
        logic rd_age;     // read the entry at the requested age
        logic rd_last;    // read the newest entry
        logic scan_clr;   // start a severity walk
        logic scan_step;  // read the next slot of the walk
        logic set_ok;
        logic set_ent;
        logic out_load;   // move the result into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [OpW-1:0] op;
        logic           log_en;
        logic           age_ok;
        logic           empty;
        logic           scan_done;
        logic           out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/circular_error_log_top.sv =====
// circular error log: a ring of LOG_DEPTH entries (code, severity, context,
// timestamp, boot number) driven by one request stream and one result stream.
// requests arrive on the s_axis channel, op in tuser, the entry fields and age
// index in tdata; every request gives exactly one result on m_axis, with the
// ok flag in tuser and the returned entry, match count and fill level in tdata.
// configuration writes (index 0 log enable, index 1 boot number) go through
// the cfg channel, which is always ready.
// one request is handled at a time. record, clear and misses go from the execute
// state straight to the finishing state, read and latest pass a read-wait state
// first; count by severity walks the held entries through the single read port
// of the entry memory, one per cycle. the next request is taken in the cycle
// after the result enters the output register.
// reset empties the ring, enables logging and zeroes the boot number; the
// memory itself is not cleared, only held entries are ever read.
// when the receiver stalls the result holds in the output register and the
// next result waits in the finishing state until the register frees.
`default_nettype none

module circular_error_log_top
    import cel_pkg::*;
#(
    parameter int LOG_DEPTH = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // err_code[15:0], sev_level[23:16], context_word[55:24], now_ms[87:56],
    // age_index[95:88]
    input  wire logic [95:0]  i_s_axis_tdata,
    // op[2:0]
    input  wire logic [2:0]   i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // out_code[15:0], out_severity[23:16], out_context[55:24], out_time[87:56],
    // out_boot[119:88], match_count[124:120], fill_level[129:125], zeros above
    output logic [135:0]      o_m_axis_tdata,
    // ok[0]
    output logic              o_m_axis_tuser,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic         i_cfg_index,
    input  wire logic [31:0]  i_cfg_data
);

    t_cmd            cmd;
    t_sts            sts;
    t_entry          entry;
    logic [CntW-1:0] match_count;
    logic [CntW-1:0] fill_level;

    assign o_cfg_ready = 1'b1;

    cel_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cel_dp #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_op           (i_s_axis_tuser),
        .i_err_code     (i_s_axis_tdata[15:0]),
        .i_sev_level    (i_s_axis_tdata[23:16]),
        .i_context_word (i_s_axis_tdata[55:24]),
        .i_now_ms       (i_s_axis_tdata[87:56]),
        .i_age_index    (i_s_axis_tdata[95:88]),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_ok           (o_m_axis_tuser),
        .o_entry        (entry),
        .o_match_count  (match_count),
        .o_fill_level   (fill_level)
    );

    assign o_m_axis_tdata = {6'b0, fill_level, match_count, entry};

endmodule

`default_nettype wire

// ===== rtl/cel_ctrl.sv =====
`default_nettype none

module cel_ctrl
    import cel_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDW,
        S_SCAN,
        S_FIN
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FIN;
                case (i_sts.op)
                    OP_RECORD: begin
                        o_cmd.rec    = i_sts.log_en;
                        o_cmd.set_ok = i_sts.log_en;
                    end
                    OP_READ: begin
                        if (i_sts.age_ok) begin
                            o_cmd.rd_age  = 1'b1;
                            o_cmd.set_ok  = 1'b1;
                            o_cmd.set_ent = 1'b1;
                            n_state       = S_RDW;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.clear  = 1'b1;
                        o_cmd.set_ok = 1'b1;
                    end
                    OP_LATEST: begin
                        if (!i_sts.empty) begin
                            o_cmd.rd_last = 1'b1;
                            o_cmd.set_ok  = 1'b1;
                            o_cmd.set_ent = 1'b1;
                            n_state       = S_RDW;
                        end
                    end
                    OP_COUNT: begin
                        o_cmd.scan_clr = 1'b1;
                        o_cmd.set_ok   = 1'b1;
                        n_state        = S_SCAN;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_RDW: begin
                n_state = S_FIN;
            end
            S_SCAN: begin
                // the compare of the last read lands on the edge that leaves
                if (i_sts.scan_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/cel_dp.sv =====
`default_nettype none

module cel_dp
    import cel_pkg::*;
#(
    parameter int LOG_DEPTH = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_sts                     o_sts,
    input  wire logic [OpW-1:0]      i_op,
    input  wire logic [CodeW-1:0]    i_err_code,
    input  wire logic [SevW-1:0]     i_sev_level,
    input  wire logic [WordW-1:0]    i_context_word,
    input  wire logic [WordW-1:0]    i_now_ms,
    input  wire logic [AgeW-1:0]     i_age_index,
    input  wire logic                i_cfg_valid,
    input  wire logic                i_cfg_index,
    input  wire logic [WordW-1:0]    i_cfg_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic                     o_ok,
    output t_entry                   o_entry,
    output logic [CntW-1:0]          o_match_count,
    output logic [CntW-1:0]          o_fill_level
);

    localparam int AW   = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CW   = $clog2(LOG_DEPTH + 1);
    localparam int AGW  = (CW > AgeW) ? CW : AgeW;
    localparam int SUMW = AGW + 1;

    t_entry r_mem [LOG_DEPTH];
    t_entry r_rdata;

    logic [OpW-1:0]   r_op;
    logic [CodeW-1:0] r_code;
    logic [SevW-1:0]  r_sev;
    logic [WordW-1:0] r_ctx;
    logic [WordW-1:0] r_tms;
    logic [AgeW-1:0]  r_age;

    logic             r_log_en;
    logic [WordW-1:0] r_boot;

    logic [AW-1:0]    r_wp;
    logic [CW-1:0]    r_held;
    logic [CW-1:0]    r_scan;
    logic [CW-1:0]    r_cnt;
    logic             r_cmp_vld;
    logic             r_ok;
    logic             r_ent;

    logic             r_ovalid;
    logic             r_ook;
    t_entry           r_oentry;
    logic [CntW-1:0]  r_omatch;
    logic [CntW-1:0]  r_ofill;

    logic             full;
    logic [SUMW-1:0]  age_sum;
    logic [SUMW-1:0]  age_wrap;
    logic [AW-1:0]    age_slot;
    logic [AW-1:0]    last_slot;
    logic [AW-1:0]    wp_next;
    logic [AW-1:0]    rd_addr;
    logic             rd_en;

    assign full      = (r_held == CW'(LOG_DEPTH));
    assign age_sum   = SUMW'(full ? r_wp : '0) + SUMW'(r_age);
    assign age_wrap  = (age_sum >= SUMW'(LOG_DEPTH)) ? age_sum - SUMW'(LOG_DEPTH) : age_sum;
    assign age_slot  = age_wrap[AW-1:0];
    assign last_slot = (r_wp == '0) ? AW'(LOG_DEPTH - 1) : r_wp - AW'(1);
    assign wp_next   = (r_wp == AW'(LOG_DEPTH - 1)) ? '0 : r_wp + AW'(1);

    // held entries are the physical slots below the fill level
    assign rd_addr = i_cmd.rd_age  ? age_slot :
                     i_cmd.rd_last ? last_slot : r_scan[AW-1:0];
    assign rd_en   = i_cmd.rd_age | i_cmd.rd_last | i_cmd.scan_step;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rec) begin
            r_mem[r_wp] <= '{boot: r_boot, tms: r_tms, ctx: r_ctx, sev: r_sev, code: r_code};
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_code <= i_err_code;
            r_sev  <= i_sev_level;
            r_ctx  <= i_context_word;
            r_tms  <= i_now_ms;
            r_age  <= i_age_index;
        end
        if (i_cmd.out_load) begin
            r_ook    <= r_ok;
            r_oentry <= r_ent ? r_rdata : '0;
            r_omatch <= CntW'(r_cnt);
            r_ofill  <= CntW'(r_held);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_en  <= 1'b1;
            r_boot    <= '0;
            r_wp      <= '0;
            r_held    <= '0;
            r_scan    <= '0;
            r_cnt     <= '0;
            r_cmp_vld <= 1'b0;
            r_ok      <= 1'b0;
            r_ent     <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_LOG_ENABLE:  r_log_en <= i_cfg_data[0];
                    CFG_BOOT_NUMBER: r_boot   <= i_cfg_data;
                    default:         r_boot   <= r_boot;
                endcase
            end

            if (i_cmd.load) begin
                r_ok  <= 1'b0;
                r_ent <= 1'b0;
                r_cnt <= '0;
            end else begin
                if (i_cmd.set_ok) begin
                    r_ok <= 1'b1;
                end
                if (i_cmd.set_ent) begin
                    r_ent <= 1'b1;
                end
                if (i_cmd.scan_clr) begin
                    r_cnt <= '0;
                end else if (r_cmp_vld && r_rdata.sev == r_sev) begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end

            if (i_cmd.rec) begin
                r_wp <= wp_next;
                if (!full) begin
                    r_held <= r_held + CW'(1);
                end
            end else if (i_cmd.clear) begin
                r_wp   <= '0;
                r_held <= '0;
            end

            if (i_cmd.scan_clr) begin
                r_scan <= '0;
            end else if (i_cmd.scan_step) begin
                r_scan <= r_scan + CW'(1);
            end
            r_cmp_vld <= i_cmd.scan_step;

            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.log_en    = r_log_en;
    assign o_sts.age_ok    = (AGW'(r_age) < AGW'(r_held));
    assign o_sts.empty     = (r_held == '0);
    assign o_sts.scan_done = (r_scan == r_held);
    assign o_sts.out_free  = !r_ovalid || i_out_ready;

    assign o_out_valid   = r_ovalid;
    assign o_ok          = r_ook;
    assign o_entry       = r_oentry;
    assign o_match_count = r_omatch;
    assign o_fill_level  = r_ofill;

endmodule

`default_nettype wire

// ===== rtl/cel_checker.sv =====
`default_nettype none

module cel_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_axis_tvalid,
    input wire logic         o_s_axis_tready,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [135:0] o_m_axis_tdata,
    input wire logic         o_m_axis_tuser,
    input wire logic         o_cfg_ready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // one request at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request taken while another is in work");

    // entry fields only come with ok
    a_entry_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[119:0] != '0) |-> o_m_axis_tuser)
        else $error("entry returned without ok");

    // a non-zero match count only comes with ok
    a_count_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[124:120] != '0) |-> o_m_axis_tuser)
        else $error("match count without ok");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind circular_error_log_top cel_checker u_cel_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_cfg_ready     (o_cfg_ready)
);

`default_nettype wire

// ===== tb/tb_circular_error_log_top.sv =====
module tb_circular_error_log_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cel_pkg::*;

    localparam int LogDepth   = 16;
    localparam int SlotW      = 4;
    localparam int CycleLimit = 300000;

    // op codes the block does not implement
    localparam logic [OpW-1:0] OP_UNUSED5 = 3'd5;
    localparam logic [OpW-1:0] OP_UNUSED6 = 3'd6;
    localparam logic [OpW-1:0] OP_UNUSED7 = 3'd7;

    localparam t_entry NO_ENTRY = '0;

    typedef struct packed {
        logic            ok;
        logic [CntW-1:0] fill;
        logic [CntW-1:0] match;
        t_entry          ent;
    } log_result_t;

    typedef enum logic {ROW_REQUEST, ROW_REG_WRITE} row_kind_e;

    typedef struct packed {
        row_kind_e        kind;
        logic [OpW-1:0]   op;
        t_entry           fields;
        logic [AgeW-1:0]  age;
        logic             reg_index;
        logic [WordW-1:0] reg_value;
        logic             typed;
        log_result_t      want;
    } plan_row_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [95:0]  i_s_axis_tdata;
    logic [2:0]   i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [135:0] o_m_axis_tdata;
    logic         o_m_axis_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic         i_cfg_index;
    logic [31:0]  i_cfg_data;

    // predictor state
    t_entry           ring [LogDepth];
    logic [SlotW-1:0] wr_ptr;
    logic [CntW-1:0]  held;
    logic             log_en;
    logic [WordW-1:0] boot_no;

    log_result_t pending_results [$];
    plan_row_t   plan [$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    int          tx_idle_pct = 9;
    int          rx_idle_pct = 46;

    circular_error_log_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CycleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_entry entry_of(input logic [CodeW-1:0] code, input logic [SevW-1:0] sev,
                                        input logic [WordW-1:0] ctx, input logic [WordW-1:0] tms,
                                        input logic [WordW-1:0] boot);
        t_entry e;
        e.code = code;
        e.sev  = sev;
        e.ctx  = ctx;
        e.tms  = tms;
        e.boot = boot;
        return e;
    endfunction

    function automatic plan_row_t req_row(input logic [OpW-1:0] op, input logic [CodeW-1:0] code,
                                          input logic [SevW-1:0] sev, input logic [WordW-1:0] ctx,
                                          input logic [WordW-1:0] tms, input logic [AgeW-1:0] age);
        plan_row_t r;
        r        = '0;
        r.kind   = ROW_REQUEST;
        r.op     = op;
        r.fields = entry_of(code, sev, ctx, tms, '0);
        r.age    = age;
        return r;
    endfunction

    function automatic plan_row_t reg_row(input logic index, input logic [WordW-1:0] value);
        plan_row_t r;
        r           = '0;
        r.kind      = ROW_REG_WRITE;
        r.reg_index = index;
        r.reg_value = value;
        return r;
    endfunction

    function automatic plan_row_t typed_row(input plan_row_t r, input logic ok, input t_entry ent,
                                            input logic [CntW-1:0] match,
                                            input logic [CntW-1:0] fill);
        plan_row_t t;
        t            = r;
        t.typed      = 1'b1;
        t.want.ok    = ok;
        t.want.ent   = ent;
        t.want.match = match;
        t.want.fill  = fill;
        return t;
    endfunction

    // advances the ring for one request and returns the response it gives
    function automatic log_result_t apply_request(input plan_row_t row);
        log_result_t      res;
        logic [SlotW-1:0] base;
        logic [CntW-1:0]  hits;
        res  = '0;
        hits = '0;
        // oldest entry sits at slot 0 until the ring has wrapped
        base = (held == CntW'(LogDepth)) ? wr_ptr : '0;
        case (row.op)
            OP_RECORD: begin
                if (log_en) begin
                    ring[wr_ptr]      = row.fields;
                    ring[wr_ptr].boot = boot_no;
                    wr_ptr            = wr_ptr + 1'b1;
                    if (held != CntW'(LogDepth)) held = held + 1'b1;
                    res.ok = 1'b1;
                end
            end
            OP_READ: begin
                if (row.age < AgeW'(held)) begin
                    res.ok  = 1'b1;
                    res.ent = ring[base + SlotW'(row.age)];
                end
            end
            OP_CLEAR: begin
                wr_ptr = '0;
                held   = '0;
                res.ok = 1'b1;
            end
            OP_LATEST: begin
                if (held != '0) begin
                    res.ok  = 1'b1;
                    res.ent = ring[wr_ptr - 1'b1];
                end
            end
            OP_COUNT: begin
                for (int i = 0; i < LogDepth; i++) begin
                    if (CntW'(i) < held && ring[base + SlotW'(i)].sev == row.fields.sev)
                        hits = hits + 1'b1;
                end
                res.ok    = 1'b1;
                res.match = hits;
            end
            default: ;
        endcase
        res.fill = held;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [WordW-1:0] want,
                               input logic [WordW-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        log_result_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no request outstanding");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("ok", WordW'(want.ok), WordW'(o_m_axis_tuser));
                check_field("out_code", WordW'(want.ent.code), WordW'(o_m_axis_tdata[15:0]));
                check_field("out_severity", WordW'(want.ent.sev),
                            WordW'(o_m_axis_tdata[23:16]));
                check_field("out_context", want.ent.ctx, o_m_axis_tdata[55:24]);
                check_field("out_time", want.ent.tms, o_m_axis_tdata[87:56]);
                check_field("out_boot", want.ent.boot, o_m_axis_tdata[119:88]);
                check_field("match_count", WordW'(want.match), WordW'(o_m_axis_tdata[124:120]));
                check_field("fill_level", WordW'(want.fill), WordW'(o_m_axis_tdata[129:125]));
                check_field("tdata padding", '0, WordW'(o_m_axis_tdata[135:130]));
            end
        end
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic send_request(input plan_row_t row);
        log_result_t predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {row.age, row.fields.tms, row.fields.ctx, row.fields.sev,
                            row.fields.code};
        i_s_axis_tuser  <= row.op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        // the ring advances for typed rows too
        predicted = apply_request(row);
        pending_results.push_back(row.typed ? row.want : predicted);
        @(negedge i_clk);
    endtask

    // stop sending and wait for every outstanding response
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic index, input logic [WordW-1:0] value);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == CFG_LOG_ENABLE) log_en = value[0];
        else boot_no = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_request();
        logic [OpW-1:0]  op;
        logic [SevW-1:0] sev;
        logic [AgeW-1:0] age;
        int              pick;
        pick = $urandom_range(99);
        if (pick < 42) op = OP_RECORD;
        else if (pick < 66) op = OP_READ;
        else if (pick < 79) op = OP_COUNT;
        else if (pick < 90) op = OP_LATEST;
        else if (pick < 92) op = OP_CLEAR;
        else op = OpW'($urandom_range(OP_UNUSED7, OP_UNUSED5));
        // a small pool of severities so that counts find matches
        sev = ($urandom_range(3) == 0) ? SevW'($urandom) : SevW'($urandom_range(3));
        // mostly held ages, now and then one just past the fill level or anything
        age = ($urandom_range(4) == 0) ? AgeW'($urandom) : AgeW'($urandom_range(held + 1));
        send_request(req_row(op, CodeW'($urandom), sev, $urandom, $urandom, age));
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = 1'b0;
        i_cfg_data      = '0;
        wr_ptr          = '0;
        held            = '0;
        log_en          = 1'b1;
        boot_no         = '0;

        // empty ring, unknown ops, extremes of the entry fields and the first records read back
        plan.push_back(typed_row(req_row(OP_LATEST, '0, '0, '0, '0, '0), 1'b0, NO_ENTRY, 0, 0));
        plan.push_back(typed_row(req_row(OP_READ, '0, '0, '0, '0, '0), 1'b0, NO_ENTRY, 0, 0));
        plan.push_back(typed_row(req_row(OP_COUNT, '0, '0, '0, '0, '0), 1'b1, NO_ENTRY, 0, 0));
        plan.push_back(typed_row(req_row(OP_UNUSED5, '1, '1, '1, '1, '1), 1'b0, NO_ENTRY, 0, 0));
        plan.push_back(typed_row(req_row(OP_UNUSED7, '0, '0, '0, '0, '0), 1'b0, NO_ENTRY, 0, 0));
        plan.push_back(typed_row(req_row(OP_RECORD, '1, '1, '1, '1, '0), 1'b1, NO_ENTRY, 0, 1));
        plan.push_back(typed_row(req_row(OP_LATEST, '0, '0, '0, '0, '0), 1'b1,
                                 entry_of('1, '1, '1, '1, '0), 0, 1));
        plan.push_back(typed_row(req_row(OP_RECORD, '0, '0, '0, '0, '1), 1'b1, NO_ENTRY, 0, 2));
        plan.push_back(typed_row(req_row(OP_READ, '0, '0, '0, '0, '1), 1'b0, NO_ENTRY, 0, 2));
        plan.push_back(typed_row(req_row(OP_COUNT, '0, '1, '0, '0, '0), 1'b1, NO_ENTRY, 1, 2));
        plan.push_back(reg_row(CFG_BOOT_NUMBER, '1));
        // wrap the ring with one severity, so the count reaches the depth
        for (int k = 0; k < LogDepth; k++)
            plan.push_back(req_row(OP_RECORD, CodeW'(16'h1000 + k), 8'h5a, $urandom, $urandom,
                                   AgeW'(k)));
        plan.push_back(req_row(OP_READ, '0, '0, '0, '0, 8'd0));
        plan.push_back(req_row(OP_READ, '0, '0, '0, '0, 8'd15));
        plan.push_back(typed_row(req_row(OP_READ, '0, '0, '0, '0, 8'd16), 1'b0, NO_ENTRY, 0, 16));
        plan.push_back(req_row(OP_COUNT, '0, 8'h5a, '0, '0, '0));
        plan.push_back(reg_row(CFG_LOG_ENABLE, '0));
        plan.push_back(typed_row(req_row(OP_RECORD, 16'h00ff, 8'h01, '1, '0, '0), 1'b0,
                                 NO_ENTRY, 0, 16));
        plan.push_back(req_row(OP_LATEST, '0, '0, '0, '0, '0));
        plan.push_back(reg_row(CFG_LOG_ENABLE, 32'd1));
        plan.push_back(typed_row(req_row(OP_CLEAR, '0, '0, '0, '0, '0), 1'b1, NO_ENTRY, 0, 0));
        plan.push_back(typed_row(req_row(OP_LATEST, '0, '0, '0, '0, '0), 1'b0, NO_ENTRY, 0, 0));
        plan.push_back(typed_row(req_row(OP_UNUSED6, '0, '0, '0, '0, '0), 1'b0, NO_ENTRY, 0, 0));

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG_WRITE) write_reg(plan[i].reg_index, plan[i].reg_value);
            else send_request(plan[i]);
        end

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 46 : 0;
            rx_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 9 : 0;
            write_reg(CFG_BOOT_NUMBER, (phase == 1) ? '0 : $urandom);
            repeat (420) random_request();
            if (phase == 1) begin
                // records are dropped while logging is off
                write_reg(CFG_LOG_ENABLE, '0);
                repeat (40) random_request();
                write_reg(CFG_LOG_ENABLE, 32'd1);
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cel_pkg.sv
rtl/cel_ctrl.sv
rtl/cel_dp.sv
rtl/circular_error_log_top.sv
rtl/cel_checker.sv
tb/tb_circular_error_log_top.sv
